/* design/sha256_pkg.sv */
// Package: SHA-256 constants, types and round functions shared by the hasher modules.
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned LenStart = 56;

  typedef enum logic [1:0] {
    ACT_ABSORB   = 2'd0,
    ACT_FINALIZE = 2'd1,
    ACT_RESTART  = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       write_byte;  // store a byte at the buffer position
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       load_init;   // reload initial hash, clear length
    logic       start_blk;   // latch hash into working variables, begin
    logic       add_len;     // add the given bit count to the length
    logic [9:0] len_add;
    logic       set_len;     // write length bytes into last 8 slots
  } dp_cmd_t;

  typedef struct packed {
    logic busy;     // compression in progress
  } dp_sts_t;

  localparam logic [WordW-1:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] ssig0(input logic [WordW-1:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] ssig1(input logic [WordW-1:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

/* design/sha256_if.sv */
// Interfaces: input and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* design/sha256_datapath.sv */
// Datapath: block buffer memory, message schedule, round unit, hash and length registers.
`timescale 1ns / 1ps
module sha256_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::dp_cmd_t  cmd,
  output sha256_pkg::dp_sts_t  sts,
  input  logic [2:0]           rd_idx,
  output logic [31:0]          rd_word
);

  logic [31:0] buf_mem [16];
  logic [31:0] hash_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [63:0] len_r;
  logic [6:0]  step_r;    // 0..15 load words, 16..79 rounds, 80 fold
  logic        busy_r;
  logic [31:0] rd_w_r;
  logic [3:0]  lwr_r;
  logic        lvalid_r;

  logic [31:0] t1, t2, w_new, w_cur;
  logic [5:0]  rnd;
  logic [3:0]  ld_word;

  assign sts.busy = busy_r;
  assign rd_word  = hash_r[rd_idx];
  assign ld_word  = step_r[3:0];
  assign rnd      = 6'(step_r - 7'd16);

  // Schedule word for this round: first 16 from buffer, then expanded.
  assign w_new = sha256_pkg::ssig1(w_r[14]) + w_r[9] + sha256_pkg::ssig0(w_r[1]) + w_r[0];
  assign w_cur = (rnd < 6'd16) ? w_r[rnd[3:0]] : w_new;

  always_comb begin
    t1 = v_r[7] + sha256_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + sha256_pkg::RoundK[rnd] + w_cur;
    t2 = sha256_pkg::bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // Buffer memory: 16 big-endian words, byte-lane writes, one registered word read.
  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      buf_mem[cmd.wr_addr[5:2]][{~cmd.wr_addr[1:0], 3'b000} +: 8] <= cmd.wr_data;
    end else if (cmd.set_len) begin
      buf_mem[4'd14] <= len_r[63:32];
      buf_mem[4'd15] <= len_r[31:0];
    end
    rd_w_r <= buf_mem[ld_word];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      step_r   <= '0;
      lvalid_r <= 1'b0;
      len_r    <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= sha256_pkg::InitHash[i];
    end else begin
      lvalid_r <= 1'b0;
      if (cmd.load_init) begin
        len_r <= '0;
        for (int i = 0; i < 8; i++) hash_r[i] <= sha256_pkg::InitHash[i];
      end
      if (cmd.add_len) begin
        len_r <= len_r + 64'(cmd.len_add);
      end
      if (cmd.start_blk) begin
        busy_r <= 1'b1;
        step_r <= '0;
        for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
      end else if (busy_r) begin
        // Load phase: read one word a cycle, write it from the read register in the cycle after.
        if (step_r < 7'd16) begin
          lvalid_r <= 1'b1;
          lwr_r    <= ld_word;
          step_r   <= step_r + 7'd1;
        end else if (step_r < 7'd80) begin
          if (rnd >= 6'd16) begin
            for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
            w_r[15] <= w_new;
          end
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          step_r <= step_r + 7'd1;
        end else begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
          busy_r <= 1'b0;
        end
      end
      if (lvalid_r) begin
        w_r[lwr_r] <= rd_w_r;
      end
    end
  end

endmodule

/* design/sha256_ctrl.sv */
// Controller: transaction decode, padding sequence and digest output state machine.
`timescale 1ns / 1ps
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  sha256_in_if.sink            in_ch,
  sha256_out_if.source         out_ch,
  output sha256_pkg::dp_cmd_t  cmd,
  input  sha256_pkg::dp_sts_t  sts,
  output logic [2:0]           rd_idx,
  input  logic [31:0]          rd_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_PAD, S_WAIT_PAD1, S_LEN, S_WAIT_FIN, S_EMIT
  } state_t;

  state_t      state_r;
  logic [5:0]  cnt_r;       // bytes pending
  logic [5:0]  pad_r;       // next pad address
  logic        fin_r;
  logic [2:0]  idx_r;
  logic        ovalid_r;
  logic [31:0] oword_r;
  logic [2:0]  oidx_r;
  logic        acc;
  logic        out_free;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign acc                = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = ovalid_r;
  assign out_ch.digest_word = oword_r;
  assign out_ch.word_index  = oidx_r;
  assign out_ch.last_word   = (oidx_r == 3'd7);
  assign out_free           = !ovalid_r || out_ch.ready;
  assign rd_idx             = idx_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (acc && in_ch.action == sha256_pkg::ACT_ABSORB && !fin_r) begin
          cmd.write_byte = 1'b1;
          cmd.wr_addr    = cnt_r;
          cmd.wr_data    = in_ch.data_byte;
          if (cnt_r == 6'd63) begin
            cmd.add_len   = 1'b1;
            cmd.len_add   = 10'd512;
            cmd.start_blk = 1'b1;
          end
        end else if (acc && in_ch.action == sha256_pkg::ACT_RESTART) begin
          cmd.load_init = 1'b1;
        end else if (acc && in_ch.action == sha256_pkg::ACT_FINALIZE && !fin_r) begin
          cmd.write_byte = 1'b1;
          cmd.wr_addr    = cnt_r;
          cmd.wr_data    = 8'h80;
          cmd.add_len    = 1'b1;
          cmd.len_add    = {1'b0, cnt_r, 3'd0};
          // 0x80 completes the block: compress it before the length block.
          if (cnt_r == 6'd63) begin
            cmd.start_blk = 1'b1;
          end
        end
      end
      S_WAIT: begin
        cmd.start_blk = 1'b0;
      end
      S_PAD: begin
        cmd.write_byte = 1'b1;
        cmd.wr_addr    = pad_r;
        cmd.wr_data    = 8'h00;
        if (pad_r == 6'd63 && cnt_r >= 6'(sha256_pkg::LenStart)) begin
          cmd.start_blk = 1'b1;
        end
      end
      S_LEN: begin
        cmd.set_len   = 1'b1;
        cmd.start_blk = 1'b1;
      end
      S_WAIT_PAD1, S_WAIT_FIN: begin
        cmd.start_blk = 1'b0;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pad_r    <= '0;
      fin_r    <= 1'b0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && out_free) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            case (in_ch.action)
              sha256_pkg::ACT_ABSORB: begin
                if (!fin_r) begin
                  cnt_r <= cnt_r + 6'd1;
                  if (cnt_r == 6'd63) state_r <= S_WAIT;
                end
              end
              sha256_pkg::ACT_RESTART: begin
                cnt_r <= '0;
                fin_r <= 1'b0;
              end
              sha256_pkg::ACT_FINALIZE: begin
                idx_r <= '0;
                if (fin_r) begin
                  state_r <= S_EMIT;
                end else if (cnt_r == 6'd63) begin
                  state_r <= S_WAIT_PAD1;   // 0x80 filled the block
                end else if (cnt_r == 6'(sha256_pkg::LenStart - 1)) begin
                  state_r <= S_LEN;         // 0x80 took the last pad byte
                end else begin
                  pad_r   <= cnt_r + 6'd1;
                  state_r <= S_PAD;
                end
              end
              default: ;
            endcase
          end
        end
        S_WAIT: begin
          if (!sts.busy) state_r <= S_IDLE;
        end
        S_PAD: begin
          pad_r <= pad_r + 6'd1;
          if (pad_r == 6'd63 && cnt_r >= 6'(sha256_pkg::LenStart)) begin
            state_r <= S_WAIT_PAD1;
          end else if (pad_r == 6'd55 && cnt_r < 6'(sha256_pkg::LenStart)) begin
            state_r <= S_LEN;
          end
        end
        S_WAIT_PAD1: begin
          // First of two blocks: wait until idle, then zero up to the length.
          if (!sts.busy && !cmd.start_blk) begin
            cnt_r   <= '0;
            pad_r   <= '0;
            state_r <= S_PAD;
          end
        end
        S_LEN: begin
          state_r <= S_WAIT_FIN;
        end
        S_WAIT_FIN: begin
          if (!sts.busy) begin
            cnt_r   <= '0;
            fin_r   <= 1'b1;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            oword_r  <= rd_word;
            oidx_r   <= idx_r;
            idx_r    <= idx_r + 3'd1;
            if (idx_r == 3'd7) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/sha256_byte_stream_hasher.sv */
// Top level: SHA-256 byte stream hasher, controller plus datapath.
`timescale 1ns / 1ps
//
//  channel | dir | handshake     | payload
//  in_     | in  | valid/ready   | action[1:0], data_byte[7:0]
//  out_    | out | valid/ready   | digest_word[31:0], word_index[2:0], last_word
//
//  The 64th byte of a block starts the compression unit, which holds input
//  ready low through 16 word loads, 64 rounds, one fold and the return to idle,
//  all run by the single round unit. Finalize zero-pads one byte a cycle up to
//  byte 55, writes the length, then runs one compression (two when 56 or more
//  bytes are pending) and emits eight words, at most one a cycle, each held
//  until the sink takes it. A second finalize only emits the digest again.
//  Reset (rst_n low, synchronous) restores the initial hash and clears counts.
module sha256_byte_stream_hasher (
  input  logic          clk,
  input  logic          rst_n,
  sha256_in_if.sink     in_ch,
  sha256_out_if.source  out_ch
);

  sha256_pkg::dp_cmd_t cmd;
  sha256_pkg::dp_sts_t sts;
  logic [2:0]          rd_idx;
  logic [31:0]         rd_word;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .cmd, .sts, .rd_idx, .rd_word
  );

  sha256_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .rd_idx, .rd_word
  );

  // Output must hold while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest_word))
    else $error("result changed while stalled");

  // No input accepted while compressing.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !in_ch.ready)
    else $error("input ready during compression");

endmodule

/* tb/sv/tb_sha256_byte_stream_hasher.sv */
// Testbench for the SHA-256 byte stream hasher: directed and random streams, local predictor.
`timescale 1ns / 1ps
module tb_sha256_byte_stream_hasher;

  // Clock and synchronous active-low reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_byte_stream_hasher dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // One expected digest word, as it should appear on the result channel.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_exp_t;

  digest_exp_t digest_q[$];

  // Predictor state, a copy of what the hasher holds.
  logic [31:0] hv [8];
  logic [7:0]  blk [64];
  int unsigned pend;
  logic [63:0] msg_bits;
  bit          done;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          long_hold = 1'b0;
  bit          timed_out = 1'b0;
  localparam int unsigned IdleLimit = 20000;

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run one compression over blk into hv.
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    {a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & f) ^ (~e & g)) +
           sha256_pkg::RoundK[i] + w[i];
      t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
    hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hv[i] = sha256_pkg::InitHash[i];
    pend = 0;
    msg_bits = '0;
    done = 1'b0;
  endtask

  // Advance the predictor by one accepted transaction and queue its digest words.
  task automatic predict_item(input sha256_pkg::action_t act, input logic [7:0] byte_in);
    int unsigned idx;
    case (act)
      sha256_pkg::ACT_ABSORB: begin
        if (!done) begin
          blk[pend] = byte_in;
          pend++;
          if (pend == sha256_pkg::BlockBytes) begin
            compress();
            msg_bits += 64'd512;
            pend = 0;
          end
        end
      end
      sha256_pkg::ACT_RESTART: restart_hash();
      sha256_pkg::ACT_FINALIZE: begin
        if (!done) begin
          idx = pend;
          blk[idx++] = 8'h80;
          if (idx > sha256_pkg::LenStart) begin
            while (idx < sha256_pkg::BlockBytes) blk[idx++] = 8'h00;
            compress();
            idx = 0;
          end
          while (idx < sha256_pkg::LenStart) blk[idx++] = 8'h00;
          msg_bits += 64'(pend) * 64'd8;
          for (int j = 0; j < 8; j++) blk[63-j] = msg_bits[8*j +: 8];
          compress();
          done = 1'b1;
        end
        for (int k = 0; k < 8; k++)
          digest_q.push_back('{hv[k], 3'(k), k == 7});
      end
      default: ;
    endcase
  endtask

  // Sender: drive at the falling edge, hold until accepted, then maybe gap.
  int unsigned burst_left = 0;

  task automatic send_item(input sha256_pkg::action_t act, input logic [7:0] byte_in);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= byte_in;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(act, byte_in);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_msg(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_item(sha256_pkg::ACT_ABSORB, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait until every digest word has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (digest_q.size() != 0 && !timed_out);
  endtask

  // Directed: empty message, byte extremes, actions after finalize and the special cases.
  task automatic test_directed();
    send_item(sha256_pkg::ACT_FINALIZE, 8'h00);
    send_item(sha256_pkg::ACT_FINALIZE, 8'hff);
    send_item(sha256_pkg::ACT_ABSORB, 8'h61);
    send_item(sha256_pkg::ACT_FINALIZE, 8'h00);
    send_item(sha256_pkg::ACT_RESTART, 8'h00);
    send_item(sha256_pkg::ACT_ABSORB, 8'hff);
    send_item(sha256_pkg::ACT_ABSORB, 8'h00);
    send_item(sha256_pkg::ACT_ABSORB, 8'haa);
    send_item(sha256_pkg::ACT_ABSORB, 8'h55);
    send_item(sha256_pkg::ACT_NONE, 8'hff);
    send_item(sha256_pkg::ACT_FINALIZE, 8'h00);
    send_item(sha256_pkg::ACT_ABSORB, 8'h12);
    send_item(sha256_pkg::ACT_FINALIZE, 8'h00);
    send_item(sha256_pkg::ACT_RESTART, 8'hff);
    drain();
  endtask

  // Lengths around the padding boundaries: 55, 56, 63 and 64 bytes.
  task automatic test_pad_boundaries();
    int unsigned lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) begin
      send_msg(lens[i]);
      send_item(sha256_pkg::ACT_FINALIZE, 8'h00);
      send_item(sha256_pkg::ACT_RESTART, 8'h00);
    end
    drain();
  endtask

  // Hold the result channel off while the sender keeps feeding, then pause to drain.
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int m = 0; m < 3; m++) begin
      send_msg($urandom_range(0, 10));
      send_item(sha256_pkg::ACT_FINALIZE, 8'h00);
      send_item(sha256_pkg::ACT_RESTART, 8'h00);
    end
    long_hold = 1'b0;
    drain();
  endtask

  // Random: mostly well-formed messages, some noise actions mixed in.
  task automatic test_random();
    int unsigned sent = 0;
    int unsigned len;
    while (sent < 60) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_item(sha256_pkg::action_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
        else
          send_item(sha256_pkg::ACT_ABSORB, 8'($urandom_range(0, 255)));
      end
      send_item(sha256_pkg::ACT_FINALIZE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
        send_item(sha256_pkg::ACT_ABSORB, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) send_item(sha256_pkg::ACT_FINALIZE, 8'h00);
      send_item(sha256_pkg::ACT_RESTART, 8'($urandom_range(0, 255)));
      sent += len + 2;
    end
    drain();
  endtask

  // Receiver: stall on its own pattern, or hold off for a long stretch.
  int unsigned stall_phase = 0;
  int unsigned hold_count = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (long_hold && hold_count < 400) begin
      hold_count <= hold_count + 1;
      out_ch.ready <= 1'b0;
    end else if (stall_phase[8]) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Check each accepted digest word against the oldest expectation.
  always @(posedge clk) begin
    digest_exp_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h index %0d", out_ch.digest_word,
                   out_ch.word_index);
      end else begin
        exp_w = digest_q.pop_front();
        if (out_ch.digest_word !== exp_w.word || out_ch.word_index !== exp_w.index ||
            out_ch.last_word !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                     exp_w.word, exp_w.index, exp_w.last, out_ch.digest_word,
                     out_ch.word_index, out_ch.last_word);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      timed_out = 1'b1;
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = sha256_pkg::ACT_NONE;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
    restart_hash();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_pad_boundaries();
    test_backpressure();
    test_random();
    repeat (100) @(negedge clk);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* files.f */
design/sha256_pkg.sv
design/sha256_if.sv
design/sha256_datapath.sv
design/sha256_ctrl.sv
design/sha256_byte_stream_hasher.sv
tb/sv/tb_sha256_byte_stream_hasher.sv
